[hw/rtl/tmie_pkg.sv]
// ----------------------------------------------------------------------------
// tmie_pkg
// Shared widths and codes for the tape machine instruction execute block:
// opcodes, output kinds and status codes.
// ----------------------------------------------------------------------------
package tmie_pkg;

   // Payload field widths
   localparam int OPCODE_WIDTH = 5;
   localparam int WORD_WIDTH   = 32;
   localparam int NEXT_WIDTH   = 33;
   localparam int KIND_WIDTH   = 2;
   localparam int STATUS_WIDTH = 2;

   // Default storage sizes
   localparam int DEF_TAPE_DEPTH  = 1024;
   localparam int DEF_STACK_DEPTH = 256;
   localparam int DEF_CELL_WIDTH  = 32;

   // Opcodes
   localparam logic [OPCODE_WIDTH-1:0] OP_INC      = 5'd0;   // +
   localparam logic [OPCODE_WIDTH-1:0] OP_DEC      = 5'd1;   // -
   localparam logic [OPCODE_WIDTH-1:0] OP_LEFT     = 5'd2;   // <
   localparam logic [OPCODE_WIDTH-1:0] OP_RIGHT    = 5'd3;   // >
   localparam logic [OPCODE_WIDTH-1:0] OP_PUTCHAR  = 5'd4;   // .
   localparam logic [OPCODE_WIDTH-1:0] OP_GETCHAR  = 5'd5;   // ,
   localparam logic [OPCODE_WIDTH-1:0] OP_LOOP_IN  = 5'd6;   // [
   localparam logic [OPCODE_WIDTH-1:0] OP_LOOP_OUT = 5'd7;   // ]
   localparam logic [OPCODE_WIDTH-1:0] OP_PUTNUM   = 5'd8;   // :
   localparam logic [OPCODE_WIDTH-1:0] OP_GETNUM   = 5'd9;   // ;
   localparam logic [OPCODE_WIDTH-1:0] OP_JUMP     = 5'd10;  // ^
   localparam logic [OPCODE_WIDTH-1:0] OP_EXIT     = 5'd11;  // !
   localparam logic [OPCODE_WIDTH-1:0] OP_NOT      = 5'd12;  // ~
   localparam logic [OPCODE_WIDTH-1:0] OP_DROP     = 5'd13;  // quote
   localparam logic [OPCODE_WIDTH-1:0] OP_ADDR     = 5'd14;  // &
   localparam logic [OPCODE_WIDTH-1:0] OP_GOTO     = 5'd15;  // $
   localparam logic [OPCODE_WIDTH-1:0] OP_SQUARE   = 5'd16;  // *
   localparam logic [OPCODE_WIDTH-1:0] OP_PUTLOG   = 5'd17;  // "
   localparam logic [OPCODE_WIDTH-1:0] OP_PUSH     = 5'd18;  // backslash
   localparam logic [OPCODE_WIDTH-1:0] OP_POP      = 5'd19;  // /
   localparam logic [OPCODE_WIDTH-1:0] OP_RANDOM   = 5'd20;  // _

   // Output kinds
   localparam logic [KIND_WIDTH-1:0] KIND_NONE = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_CHAR = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_NUM  = 2'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_LOG  = 2'd3;

   // Status codes
   localparam logic [STATUS_WIDTH-1:0] STAT_OK         = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STAT_UNDERFLOW  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STAT_TAPE_FULL  = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STAT_STACK_FULL = 2'd3;

endpackage

[hw/rtl/tape_machine_instruction_execute.sv]
// ----------------------------------------------------------------------------
// tape_machine_instruction_execute
// Executes one extended tape machine instruction per request transfer and
// returns one response carrying next position, output, exit code and status.
// ----------------------------------------------------------------------------
// In the cycle of the request transfer the tape and stack memories are read at
// the current pointer and stack top; in the execute state, once the output
// register is free or being read, the cell is modified, written back and the
// response is loaded into the output register. A new request is taken once the
// previous instruction has written back, even while its response still waits
// in the output register. After reset the block clears the tape one cell a
// cycle, all TAPE_DEPTH cells (1024 by default), and holds req_ready low until
// that pass is done.
module tape_machine_instruction_execute #(
   parameter int TAPE_DEPTH  = tmie_pkg::DEF_TAPE_DEPTH,
   parameter int STACK_DEPTH = tmie_pkg::DEF_STACK_DEPTH,
   parameter int CELL_WIDTH  = tmie_pkg::DEF_CELL_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tmie_pkg::OPCODE_WIDTH-1:0] req_opcode,
   input  logic [tmie_pkg::WORD_WIDTH-1:0]   req_position,
   input  logic [tmie_pkg::WORD_WIDTH-1:0]   req_partner_position,
   input  logic [tmie_pkg::WORD_WIDTH-1:0]   req_input_word,
   input  logic [tmie_pkg::WORD_WIDTH-1:0]   req_random_word,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tmie_pkg::NEXT_WIDTH-1:0]   rsp_next_position,
   output logic [tmie_pkg::KIND_WIDTH-1:0]   rsp_output_kind,
   output logic [tmie_pkg::WORD_WIDTH-1:0]   rsp_output_value,
   output logic [tmie_pkg::WORD_WIDTH-1:0]   rsp_exit_value,
   output logic [tmie_pkg::STATUS_WIDTH-1:0] rsp_status
);
   import tmie_pkg::*;

   localparam int TAPE_AW  = $clog2(TAPE_DEPTH);
   localparam int TSW      = $clog2(TAPE_DEPTH + 1);
   localparam int STACK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SCW      = $clog2(STACK_DEPTH + 1);
   localparam int CW       = CELL_WIDTH;

   localparam logic FSM_IDLE = 1'b0;
   localparam logic FSM_EXEC = 1'b1;

   // Memories
   logic [CW-1:0] tape_mem  [TAPE_DEPTH];
   logic [CW-1:0] stack_ram [STACK_DEPTH];

   // Control state
   logic           fsm_ff, fsm_in;
   logic [TSW-1:0] tape_size_ff, tape_size_in;
   logic [TAPE_AW-1:0] cell_ptr_ff, cell_ptr_in;
   logic [SCW-1:0] stack_cnt_ff, stack_cnt_in;
   logic [CW-1:0]  exit_code_ff, exit_code_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Tape clearing pass after reset
   logic               clr_busy_ff;
   logic [TAPE_AW-1:0] clr_ptr_ff;

   // Captured request and read data
   logic [OPCODE_WIDTH-1:0] op_ff;
   logic [WORD_WIDTH-1:0]   pos_ff, partner_ff, inw_ff, rnd_ff;
   logic [CW-1:0]           tape_rd_ff, stack_rd_ff;

   // Response registers
   logic [NEXT_WIDTH-1:0]   next_ff, next_in;
   logic [KIND_WIDTH-1:0]   kind_ff, kind_in;
   logic [WORD_WIDTH-1:0]   oval_ff, oval_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;

   // Execute-stage signals
   logic                req_xfer, exec_fire;
   logic [CW-1:0]       cell_val;
   logic [2*CW-1:0]     cell_sq;
   logic [NEXT_WIDTH-1:0] cell_wide;
   logic [TSW-1:0]      ptr_ext;
   logic                tape_we, stack_we;
   logic [TAPE_AW-1:0]  tape_waddr;
   logic [CW-1:0]       tape_wdata;

   assign req_ready = (fsm_ff == FSM_IDLE) && !clr_busy_ff;
   assign req_xfer  = req_valid && req_ready;
   assign exec_fire = (fsm_ff == FSM_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign cell_val  = tape_rd_ff;
   assign cell_sq   = cell_val * cell_val;
   assign cell_wide = NEXT_WIDTH'(cell_val);
   assign ptr_ext   = TSW'(cell_ptr_ff);

   // Instruction decode and state update
   always_comb begin
      next_in      = NEXT_WIDTH'(pos_ff) + NEXT_WIDTH'(1);
      kind_in      = KIND_NONE;
      oval_in      = '0;
      status_in    = STAT_OK;
      cell_ptr_in  = cell_ptr_ff;
      tape_size_in = tape_size_ff;
      stack_cnt_in = stack_cnt_ff;
      exit_code_in = exit_code_ff;
      tape_we      = 1'b0;
      tape_waddr   = cell_ptr_ff;
      tape_wdata   = '0;
      stack_we     = 1'b0;

      case (op_ff)
         OP_INC: begin
            tape_we    = 1'b1;
            tape_wdata = cell_val + CW'(1);
         end
         OP_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = cell_val - CW'(1);
         end
         OP_LEFT: begin
            if (cell_ptr_ff == '0) begin
               status_in = STAT_UNDERFLOW;
            end else begin
               cell_ptr_in = cell_ptr_ff - TAPE_AW'(1);
            end
         end
         OP_RIGHT: begin
            if (ptr_ext + TSW'(1) >= tape_size_ff) begin
               if (tape_size_ff >= TSW'(TAPE_DEPTH)) begin
                  status_in = STAT_TAPE_FULL;
               end else begin
                  tape_size_in = ptr_ext + TSW'(2);
                  cell_ptr_in  = cell_ptr_ff + TAPE_AW'(1);
               end
            end else begin
               cell_ptr_in = cell_ptr_ff + TAPE_AW'(1);
            end
         end
         OP_PUTCHAR: begin
            kind_in = KIND_CHAR;
            oval_in = WORD_WIDTH'(cell_val[7:0]);
         end
         OP_GETCHAR, OP_GETNUM: begin
            tape_we    = 1'b1;
            tape_wdata = inw_ff[CW-1:0];
         end
         OP_LOOP_IN: begin
            if (cell_val == '0) next_in = NEXT_WIDTH'(partner_ff) + NEXT_WIDTH'(1);
         end
         OP_LOOP_OUT: begin
            if (cell_val != '0) next_in = NEXT_WIDTH'(partner_ff) + NEXT_WIDTH'(1);
         end
         OP_PUTNUM: begin
            kind_in = KIND_NUM;
            oval_in = WORD_WIDTH'(cell_val);
         end
         OP_JUMP: begin
            next_in = cell_wide + NEXT_WIDTH'(1);
         end
         OP_EXIT: begin
            exit_code_in = cell_val;
         end
         OP_NOT: begin
            tape_we    = 1'b1;
            tape_wdata = (cell_val == '0) ? CW'(1) : '0;
         end
         OP_DROP: begin
            // clear the last live cell; shrink and clamp unless only one is left
            tape_we = 1'b1;
            if (tape_size_ff <= TSW'(1)) begin
               tape_waddr = '0;
            end else begin
               tape_size_in = tape_size_ff - TSW'(1);
               tape_waddr   = TAPE_AW'(tape_size_ff - TSW'(1));
               if (ptr_ext >= tape_size_ff - TSW'(1)) begin
                  cell_ptr_in = TAPE_AW'(tape_size_ff - TSW'(2));
               end
            end
         end
         OP_ADDR: begin
            tape_we    = 1'b1;
            tape_wdata = CW'(cell_ptr_ff);
         end
         OP_GOTO: begin
            if (cell_wide >= NEXT_WIDTH'(TAPE_DEPTH)) begin
               status_in = STAT_TAPE_FULL;
            end else begin
               cell_ptr_in = TAPE_AW'(cell_wide);
               if (NEXT_WIDTH'(tape_size_ff) <= cell_wide) begin
                  tape_size_in = TSW'(cell_wide + NEXT_WIDTH'(1));
               end
            end
         end
         OP_SQUARE: begin
            tape_we    = 1'b1;
            tape_wdata = cell_sq[CW-1:0];
         end
         OP_PUTLOG: begin
            kind_in = KIND_LOG;
            oval_in = WORD_WIDTH'(cell_val[7:0]);
         end
         OP_PUSH: begin
            if (stack_cnt_ff >= SCW'(STACK_DEPTH)) begin
               status_in = STAT_STACK_FULL;
            end else begin
               stack_we     = 1'b1;
               stack_cnt_in = stack_cnt_ff + SCW'(1);
               tape_we      = 1'b1;
            end
         end
         OP_POP: begin
            if (stack_cnt_ff != '0) begin
               stack_cnt_in = stack_cnt_ff - SCW'(1);
               tape_we      = 1'b1;
               tape_wdata   = stack_rd_ff;
            end
         end
         OP_RANDOM: begin
            tape_we    = 1'b1;
            tape_wdata = rnd_ff[CW-1:0];
         end
         default: begin
         end
      endcase
   end

   // Sequencer and output register control
   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         FSM_IDLE: if (req_xfer) fsm_in = FSM_EXEC;
         FSM_EXEC: if (exec_fire) fsm_in = FSM_IDLE;
         default:  fsm_in = FSM_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= FSM_IDLE;
         tape_size_ff <= TSW'(1);
         cell_ptr_ff  <= '0;
         stack_cnt_ff <= '0;
         exit_code_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_fire) begin
            tape_size_ff <= tape_size_in;
            cell_ptr_ff  <= cell_ptr_in;
            stack_cnt_ff <= stack_cnt_in;
            exit_code_ff <= exit_code_in;
         end
      end
   end

   // Clearing pass: one tape cell a cycle from reset release
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_ptr_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_ptr_ff <= clr_ptr_ff + TAPE_AW'(1);
         if (clr_ptr_ff == TAPE_AW'(TAPE_DEPTH - 1)) clr_busy_ff <= 1'b0;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff      <= req_opcode;
         pos_ff     <= req_position;
         partner_ff <= req_partner_position;
         inw_ff     <= req_input_word;
         rnd_ff     <= req_random_word;
      end
   end

   // Tape memory: read on transfer, cleared after reset, write back on execute
   always_ff @(posedge clock) begin
      if (req_xfer) tape_rd_ff <= tape_mem[cell_ptr_ff];
      if (clr_busy_ff) tape_mem[clr_ptr_ff] <= '0;
      else if (exec_fire && tape_we) tape_mem[tape_waddr] <= tape_wdata;
   end

   // Stack memory: top entry read on transfer, push written on execute
   always_ff @(posedge clock) begin
      if (req_xfer) stack_rd_ff <= stack_ram[STACK_AW'(stack_cnt_ff - SCW'(1))];
      if (exec_fire && stack_we) stack_ram[STACK_AW'(stack_cnt_ff)] <= cell_val;
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (exec_fire) begin
         next_ff   <= next_in;
         kind_ff   <= kind_in;
         oval_ff   <= oval_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_position = next_ff;
   assign rsp_output_kind   = kind_ff;
   assign rsp_output_value  = oval_ff;
   assign rsp_exit_value    = WORD_WIDTH'(exit_code_ff);
   assign rsp_status        = status_ff;

endmodule
